/* hw/rtl/circle_pair_collision_resolver_defines.svh */
// assertion macros for the circle pair resolver
`ifndef CIRCLE_PAIR_COLLISION_RESOLVER_DEFINES_SVH
`define CIRCLE_PAIR_COLLISION_RESOLVER_DEFINES_SVH

// same-cycle implication
`define CPCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpcr assertion failed");

// next-cycle implication
`define CPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpcr assertion failed");

`endif

/* hw/rtl/cpcr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cpcr_pkg;
    localparam int POS_W   = 24;
    localparam int DIFF_W  = 25;
    localparam int RAD_W   = 16;
    localparam int SUM_W   = 17;
    localparam int MAG_W   = 17;
    localparam int SQR_W   = 50;
    localparam int QS_W    = 51;
    localparam int Q_W     = 34;
    localparam int ROOT_W  = 17;
    localparam int PROD_W  = 33;
    localparam int LS_W    = 34;
    localparam int NUM_W   = 50;
    localparam int DEN_W   = 36;
    localparam int QUO_W   = 15;
    localparam int PUSH_W  = 16;
    localparam int SQ_LAT  = ROOT_W;
    localparam int DIV_LAT = QUO_W;
    localparam logic [QS_W-1:0] TINY_Q16 = QS_W'(6);

    typedef struct packed {
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
        logic             neg_x;
        logic             neg_y;
        logic [SUM_W-1:0] sum;
        logic [RAD_W-1:0] a_radius;
        logic [RAD_W-1:0] b_radius;
        logic             hit;
        logic             en_a;
        logic             en_b;
    } side_sq_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic hit;
        logic en_a;
        logic en_b;
    } side_dv_t;
endpackage
`default_nettype wire

/* hw/rtl/cpcr_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module cpcr_sqrt
(
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [cpcr_pkg::Q_W-1:0]    q,
    output logic      [cpcr_pkg::ROOT_W-1:0] root
);
    localparam int RW = cpcr_pkg::ROOT_W;
    localparam int TW = 2 * RW + 2;

    logic [TW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        localparam int BIT_I = RW - 1 - k;
        logic [TW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [TW-1:0] trial;
        logic [TW-1:0] rem_next;
        logic [RW-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = TW'(q);
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        always_comb
        begin
            trial = (TW'(root_in) << (BIT_I + 1)) + (TW'(1) << (2 * BIT_I));
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (RW'(1) << BIT_I);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root = root_reg[RW-1];
endmodule
`default_nettype wire

/* hw/rtl/cpcr_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module cpcr_div
(
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [cpcr_pkg::NUM_W-1:0] num,
    input  wire logic [cpcr_pkg::DEN_W-1:0] den,
    output logic      [cpcr_pkg::QUO_W-1:0] quo
);
    localparam int QW = cpcr_pkg::QUO_W;
    localparam int NW = cpcr_pkg::NUM_W;
    localparam int DW = cpcr_pkg::DEN_W;
    localparam int CW = DW + QW;

    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int BIT_I = QW - 1 - k;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [CW-1:0] trial;
        logic [NW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        always_comb
        begin
            trial = CW'(den_in) << BIT_I;
            if (CW'(rem_in) >= trial)
            begin
                rem_next = NW'(CW'(rem_in) - trial);
                quo_next = quo_in | (QW'(1) << BIT_I);
            end
            else
            begin
                rem_next = rem_in;
                quo_next = quo_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[QW-1];
endmodule
`default_nettype wire

/* hw/rtl/circle_pair_collision_resolver.sv */
// channel  | dir | tdata                                  | tuser
// s_axis   | in  | a_x a_y a_radius a_sensor a_static b_* | mode
// m_axis   | out | a_push_x a_push_y b_push_x b_push_y    | hit
//
// one item per cycle sustained while the output is not stalled
// depth set by the 17-stage square root and the 15-stage dividers
// rst_n clears the valid bits only, payload registers hold no reset
// a stalled output freezes the whole pipeline, nothing lost or repeated
`timescale 1ns / 1ps
`default_nettype none
`include "circle_pair_collision_resolver_defines.svh"
module circle_pair_collision_resolver
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // a_x, a_y, a_radius, a_sensor, a_static, b_x, b_y, b_radius, b_sensor, b_static, pad
    input  wire logic [135:0] s_axis_tdata,
    // mode
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // a_push_x, a_push_y, b_push_x, b_push_y
    output logic [63:0]       m_axis_tdata,
    // hit
    output logic [0:0]        m_axis_tuser
);
    localparam int LAT = 3 + cpcr_pkg::SQ_LAT + 2 + cpcr_pkg::DIV_LAT + 1;

    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];
    assign vld_next      = {vld_reg[LAT-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // stage 1: differences and radius sum
    logic signed [cpcr_pkg::DIFF_W-1:0] dx_reg, dy_reg;
    logic [cpcr_pkg::SUM_W-1:0]         sum1_reg;
    logic [cpcr_pkg::RAD_W-1:0]         ar1_reg, br1_reg;
    logic                               mode1_reg, as1_reg, ast1_reg, bs1_reg, bst1_reg;
    logic signed [cpcr_pkg::POS_W-1:0]  in_ax, in_ay, in_bx, in_by;

    assign in_ax = s_axis_tdata[23:0];
    assign in_ay = s_axis_tdata[47:24];
    assign in_bx = s_axis_tdata[89:66];
    assign in_by = s_axis_tdata[113:90];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= cpcr_pkg::DIFF_W'(in_ax) - cpcr_pkg::DIFF_W'(in_bx);
            dy_reg    <= cpcr_pkg::DIFF_W'(in_ay) - cpcr_pkg::DIFF_W'(in_by);
            ar1_reg   <= s_axis_tdata[63:48];
            br1_reg   <= s_axis_tdata[129:114];
            sum1_reg  <= cpcr_pkg::SUM_W'(s_axis_tdata[63:48])
                         + cpcr_pkg::SUM_W'(s_axis_tdata[129:114]);
            mode1_reg <= s_axis_tuser[0];
            as1_reg   <= s_axis_tdata[64];
            ast1_reg  <= s_axis_tdata[65];
            bs1_reg   <= s_axis_tdata[130];
            bst1_reg  <= s_axis_tdata[131];
        end
    end

    // stage 2: squares
    logic [cpcr_pkg::DIFF_W-1:0] mx_abs, my_abs;
    logic [cpcr_pkg::SQR_W-1:0]  sqx_reg, sqy_reg;
    logic [cpcr_pkg::Q_W-1:0]    ss_reg;
    logic [cpcr_pkg::MAG_W-1:0]  mx2_reg, my2_reg;
    logic                        nx2_reg, ny2_reg;
    logic [cpcr_pkg::SUM_W-1:0]  sum2_reg;
    logic [cpcr_pkg::RAD_W-1:0]  ar2_reg, br2_reg;
    logic                        mode2_reg, as2_reg, ast2_reg, bs2_reg, bst2_reg;

    assign mx_abs = dx_reg[cpcr_pkg::DIFF_W-1] ? cpcr_pkg::DIFF_W'(-dx_reg)
                                               : cpcr_pkg::DIFF_W'(dx_reg);
    assign my_abs = dy_reg[cpcr_pkg::DIFF_W-1] ? cpcr_pkg::DIFF_W'(-dy_reg)
                                               : cpcr_pkg::DIFF_W'(dy_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg   <= cpcr_pkg::SQR_W'(mx_abs) * cpcr_pkg::SQR_W'(mx_abs);
            sqy_reg   <= cpcr_pkg::SQR_W'(my_abs) * cpcr_pkg::SQR_W'(my_abs);
            ss_reg    <= cpcr_pkg::Q_W'(sum1_reg) * cpcr_pkg::Q_W'(sum1_reg);
            mx2_reg   <= mx_abs[cpcr_pkg::MAG_W-1:0];
            my2_reg   <= my_abs[cpcr_pkg::MAG_W-1:0];
            nx2_reg   <= dx_reg[cpcr_pkg::DIFF_W-1];
            ny2_reg   <= dy_reg[cpcr_pkg::DIFF_W-1];
            sum2_reg  <= sum1_reg;
            ar2_reg   <= ar1_reg;
            br2_reg   <= br1_reg;
            mode2_reg <= mode1_reg;
            as2_reg   <= as1_reg;
            ast2_reg  <= ast1_reg;
            bs2_reg   <= bs1_reg;
            bst2_reg  <= bst1_reg;
        end
    end

    // stage 3: overlap test and push enables
    logic [cpcr_pkg::QS_W-1:0] qsum;
    logic                      hit3;
    logic [cpcr_pkg::Q_W-1:0]  q3_reg;
    cpcr_pkg::side_sq_t        side3_next, side3_reg;

    assign qsum = cpcr_pkg::QS_W'(sqx_reg) + cpcr_pkg::QS_W'(sqy_reg);
    assign hit3 = (qsum < cpcr_pkg::QS_W'(ss_reg)) && (qsum > cpcr_pkg::TINY_Q16);

    always_comb
    begin
        side3_next.mag_x    = mx2_reg;
        side3_next.mag_y    = my2_reg;
        side3_next.neg_x    = nx2_reg;
        side3_next.neg_y    = ny2_reg;
        side3_next.sum      = sum2_reg;
        side3_next.a_radius = ar2_reg;
        side3_next.b_radius = br2_reg;
        side3_next.hit      = hit3;
        side3_next.en_a     = hit3 && !mode2_reg && !as2_reg && !bs2_reg && !ast2_reg;
        side3_next.en_b     = hit3 && !bs2_reg && !bst2_reg && (mode2_reg || !as2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q3_reg    <= qsum[cpcr_pkg::Q_W-1:0];
            side3_reg <= side3_next;
        end
    end

    // square root with matching side line
    logic [cpcr_pkg::ROOT_W-1:0] root;
    cpcr_pkg::side_sq_t          sq_side_reg [cpcr_pkg::SQ_LAT];

    cpcr_sqrt u_sqrt
    (
        .clk  (clk),
        .en   (en),
        .q    (q3_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg[0] <= side3_reg;
            for (int i = 1; i < cpcr_pkg::SQ_LAT; i++)
                sq_side_reg[i] <= sq_side_reg[i-1];
        end
    end

    // stage m1: penetration products and denominator
    cpcr_pkg::side_sq_t          sd;
    logic [cpcr_pkg::SUM_W-1:0]  pen;
    logic [cpcr_pkg::PROD_W-1:0] pa_reg, pb_reg;
    logic [cpcr_pkg::LS_W-1:0]   ls_reg;
    logic [cpcr_pkg::MAG_W-1:0]  mxm_reg, mym_reg;
    cpcr_pkg::side_dv_t          dvm1_reg;

    assign sd  = sq_side_reg[cpcr_pkg::SQ_LAT-1];
    assign pen = sd.sum - root;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg         <= cpcr_pkg::PROD_W'(pen) * cpcr_pkg::PROD_W'(sd.b_radius);
            pb_reg         <= cpcr_pkg::PROD_W'(pen) * cpcr_pkg::PROD_W'(sd.a_radius);
            ls_reg         <= cpcr_pkg::LS_W'(root) * cpcr_pkg::LS_W'(sd.sum);
            mxm_reg        <= sd.mag_x;
            mym_reg        <= sd.mag_y;
            dvm1_reg.neg_x <= sd.neg_x;
            dvm1_reg.neg_y <= sd.neg_y;
            dvm1_reg.hit   <= sd.hit;
            dvm1_reg.en_a  <= sd.en_a;
            dvm1_reg.en_b  <= sd.en_b;
        end
    end

    // stage m2: numerators
    logic [cpcr_pkg::NUM_W-1:0] nax_reg, nay_reg, nbx_reg, nby_reg;
    logic [cpcr_pkg::DEN_W-1:0] den_reg;
    cpcr_pkg::side_dv_t         dvm2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nax_reg  <= cpcr_pkg::NUM_W'(mxm_reg) * cpcr_pkg::NUM_W'(pa_reg);
            nay_reg  <= cpcr_pkg::NUM_W'(mym_reg) * cpcr_pkg::NUM_W'(pa_reg);
            nbx_reg  <= cpcr_pkg::NUM_W'(mxm_reg) * cpcr_pkg::NUM_W'(pb_reg);
            nby_reg  <= cpcr_pkg::NUM_W'(mym_reg) * cpcr_pkg::NUM_W'(pb_reg);
            den_reg  <= {ls_reg, 2'b00};
            dvm2_reg <= dvm1_reg;
        end
    end

    // dividers
    logic [cpcr_pkg::QUO_W-1:0] qax, qay, qbx, qby;
    cpcr_pkg::side_dv_t         dv_side_reg [cpcr_pkg::DIV_LAT];

    cpcr_div u_div_ax (.clk(clk), .en(en), .num(nax_reg), .den(den_reg), .quo(qax));
    cpcr_div u_div_ay (.clk(clk), .en(en), .num(nay_reg), .den(den_reg), .quo(qay));
    cpcr_div u_div_bx (.clk(clk), .en(en), .num(nbx_reg), .den(den_reg), .quo(qbx));
    cpcr_div u_div_by (.clk(clk), .en(en), .num(nby_reg), .den(den_reg), .quo(qby));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= dvm2_reg;
            for (int i = 1; i < cpcr_pkg::DIV_LAT; i++)
                dv_side_reg[i] <= dv_side_reg[i-1];
        end
    end

    // output stage: signs and masking
    cpcr_pkg::side_dv_t          dv;
    logic [cpcr_pkg::PUSH_W-1:0] qax_w, qay_w, qbx_w, qby_w;
    logic [cpcr_pkg::PUSH_W-1:0] pax_next, pay_next, pbx_next, pby_next;
    logic [cpcr_pkg::PUSH_W-1:0] pax_reg, pay_reg, pbx_reg, pby_reg;
    logic                        hit_reg;

    assign dv    = dv_side_reg[cpcr_pkg::DIV_LAT-1];
    assign qax_w = cpcr_pkg::PUSH_W'(qax);
    assign qay_w = cpcr_pkg::PUSH_W'(qay);
    assign qbx_w = cpcr_pkg::PUSH_W'(qbx);
    assign qby_w = cpcr_pkg::PUSH_W'(qby);

    always_comb
    begin
        pax_next = '0;
        pay_next = '0;
        pbx_next = '0;
        pby_next = '0;
        if (dv.en_a)
        begin
            pax_next = dv.neg_x ? -qax_w : qax_w;
            pay_next = dv.neg_y ? -qay_w : qay_w;
        end
        if (dv.en_b)
        begin
            pbx_next = dv.neg_x ? qbx_w : -qbx_w;
            pby_next = dv.neg_y ? qby_w : -qby_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pax_reg <= pax_next;
            pay_reg <= pay_next;
            pbx_reg <= pbx_next;
            pby_reg <= pby_next;
            hit_reg <= dv.hit;
        end
    end

    assign m_axis_tdata = {pby_reg, pbx_reg, pay_reg, pax_reg};
    assign m_axis_tuser = hit_reg;

    `CPCR_ASSERT_NOW(a_miss_no_push, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata == 64'd0)
    `CPCR_ASSERT_NOW(a_ready_rule, clk, rst_n, 1'b1,
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    `CPCR_ASSERT_NEXT(a_pipe_flow, clk, rst_n, en && vld_reg[LAT-2], m_axis_tvalid)
    `CPCR_ASSERT_NEXT(a_freeze, clk, rst_n, !en, $stable(vld_reg))
endmodule
`default_nettype wire

/* verif/circle_pair_collision_resolver_tb.sv */
`timescale 1ns / 1ps
module circle_pair_collision_resolver_tb;

    typedef struct packed {
        logic                               mode;
        logic signed [cpcr_pkg::POS_W-1:0]  a_x;
        logic signed [cpcr_pkg::POS_W-1:0]  a_y;
        logic        [cpcr_pkg::RAD_W-1:0]  a_radius;
        logic                               a_sensor;
        logic                               a_static;
        logic signed [cpcr_pkg::POS_W-1:0]  b_x;
        logic signed [cpcr_pkg::POS_W-1:0]  b_y;
        logic        [cpcr_pkg::RAD_W-1:0]  b_radius;
        logic                               b_sensor;
        logic                               b_static;
    } pair_t;

    typedef struct packed {
        logic                        hit;
        logic [cpcr_pkg::PUSH_W-1:0] a_push_x;
        logic [cpcr_pkg::PUSH_W-1:0] a_push_y;
        logic [cpcr_pkg::PUSH_W-1:0] b_push_x;
        logic [cpcr_pkg::PUSH_W-1:0] b_push_y;
    } push_t;

    typedef struct packed {
        logic  typed;
        pair_t pair;
        push_t res;
    } row_t;

    localparam int N_ROWS   = 18;
    localparam int N_RANDOM = 1650;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    push_t  pending_pushes[$];
    logic   drv_typed;
    push_t  drv_res;
    int     error_count;
    int     pairs_sent;
    int     hits_seen;
    int     results_seen;
    bit     rx_idle_on;
    row_t   rows[N_ROWS];

    circle_pair_collision_resolver dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [cpcr_pkg::PUSH_W-1:0] push_component(longint d, bit away,
        longint unsigned pen, longint unsigned r, longint unsigned len, longint unsigned s);
        bit              neg;
        longint unsigned mag;
        longint unsigned quo;
        neg = (d < 0) != away;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        quo = (mag * pen * r) / (4 * len * s);
        if (neg)
        begin
            if (quo > 32768)
                quo = 32768;
            return cpcr_pkg::PUSH_W'(-quo);
        end
        if (quo > 32767)
            quo = 32767;
        return cpcr_pkg::PUSH_W'(quo);
    endfunction

    function automatic push_t resolve_pair(pair_t p);
        push_t           r;
        longint          dx;
        longint          dy;
        longint unsigned q;
        longint unsigned s;
        longint unsigned len;
        longint unsigned pen;
        r  = '0;
        dx = longint'(p.a_x) - longint'(p.b_x);
        dy = longint'(p.a_y) - longint'(p.b_y);
        q  = longint'(dx * dx) + longint'(dy * dy);
        s  = longint'(p.a_radius) + longint'(p.b_radius);
        if (q >= s * s || q <= 6)
            return r;
        r.hit = 1'b1;
        len = int_sqrt(q);
        pen = s - len;
        if (!p.mode)
        begin
            if (p.a_sensor || p.b_sensor)
                return r;
            if (!p.a_static)
            begin
                r.a_push_x = push_component(dx, 0, pen, p.b_radius, len, s);
                r.a_push_y = push_component(dy, 0, pen, p.b_radius, len, s);
            end
            if (!p.b_static)
            begin
                r.b_push_x = push_component(dx, 1, pen, p.a_radius, len, s);
                r.b_push_y = push_component(dy, 1, pen, p.a_radius, len, s);
            end
        end
        else if (!p.b_sensor && !p.b_static)
        begin
            r.b_push_x = push_component(dx, 1, pen, p.a_radius, len, s);
            r.b_push_y = push_component(dy, 1, pen, p.a_radius, len, s);
        end
        return r;
    endfunction

    function automatic pair_t unpack_pair(logic [135:0] d, logic m);
        pair_t p;
        p.mode     = m;
        p.a_x      = d[23:0];
        p.a_y      = d[47:24];
        p.a_radius = d[63:48];
        p.a_sensor = d[64];
        p.a_static = d[65];
        p.b_x      = d[89:66];
        p.b_y      = d[113:90];
        p.b_radius = d[129:114];
        p.b_sensor = d[130];
        p.b_static = d[131];
        return p;
    endfunction

    task automatic report(string what, logic [15:0] want, logic [15:0] got);
        error_count++;
        $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
    endtask

    // input and output monitors
    always @(posedge clk)
    begin
        push_t want;
        push_t got;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            if (drv_typed)
                pending_pushes = {pending_pushes, drv_res};
            else
                pending_pushes = {pending_pushes,
                                  resolve_pair(unpack_pair(s_axis_tdata, s_axis_tuser[0]))};
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser[0], m_axis_tdata[15:0], m_axis_tdata[31:16],
                   m_axis_tdata[47:32], m_axis_tdata[63:48]};
            results_seen++;
            if (got.hit)
                hits_seen++;
            if (pending_pushes.size() == 0)
                report("unexpected item", 16'h0, {15'h0, got.hit});
            else
            begin
                want = pending_pushes.pop_front();
                if (want.hit != got.hit)
                    report("hit", {15'h0, want.hit}, {15'h0, got.hit});
                if (want.a_push_x != got.a_push_x)
                    report("a_push_x", want.a_push_x, got.a_push_x);
                if (want.a_push_y != got.a_push_y)
                    report("a_push_y", want.a_push_y, got.a_push_y);
                if (want.b_push_x != got.b_push_x)
                    report("b_push_x", want.b_push_x, got.b_push_x);
                if (want.b_push_y != got.b_push_y)
                    report("b_push_y", want.b_push_y, got.b_push_y);
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // output back-pressure
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        rx_idle_on = 1'b1;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
                rx_idle_on = !rx_idle_on;
            if (stall > 0)
            begin
                stall--;
                m_axis_tready = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                stall = gap_len();
                m_axis_tready = (stall == 0);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    task automatic send_pair(pair_t p, logic typed, push_t res, bit idle);
        int g;
        g = idle ? gap_len() : 0;
        repeat (g)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'h0, p.b_static, p.b_sensor, p.b_radius, p.b_y, p.b_x,
                         p.a_static, p.a_sensor, p.a_radius, p.a_y, p.a_x};
        s_axis_tuser  = p.mode;
        drv_typed     = typed;
        drv_res       = res;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pairs_sent++;
    endtask

    function automatic pair_t random_pair();
        pair_t p;
        int    kind;
        int    reach;
        p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        kind = $urandom_range(0, 99);
        if (kind < 80)
        begin
            // pair with a random offset per axis of up to seven tenths of the radius sum plus one
            if ($urandom_range(0, 9) == 0)
            begin
                p.a_radius = 16'hffff - 16'($urandom_range(0, 255));
                p.b_radius = 16'hffff - 16'($urandom_range(0, 255));
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                p.a_radius = 16'($urandom_range(0, 300));
                p.b_radius = 16'($urandom_range(0, 300));
            end
            reach = (int'(p.a_radius) + int'(p.b_radius)) * 7 / 10 + 1;
            p.a_x = 24'($signed($urandom_range(0, 2 * 8000000)) - 8000000);
            p.a_y = 24'($signed($urandom_range(0, 2 * 8000000)) - 8000000);
            p.b_x = p.a_x + 24'($urandom_range(0, 2 * reach) - reach);
            p.b_y = p.a_y + 24'($urandom_range(0, 2 * reach) - reach);
            if ($urandom_range(0, 2) != 0)
            begin
                p.a_sensor = 1'b0;
                p.b_sensor = 1'b0;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                p.a_static = 1'b0;
                p.b_static = 1'b0;
            end
        end
        else if (kind < 88)
        begin
            // near coincident centres
            p.b_x = p.a_x + 24'($urandom_range(0, 6) - 3);
            p.b_y = p.a_y + 24'($urandom_range(0, 6) - 3);
        end
        return p;
    endfunction

    initial
    begin
        pair_t p;
        push_t zero_res;
        error_count   = 0;
        pairs_sent    = 0;
        hits_seen     = 0;
        results_seen  = 0;
        zero_res      = '0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        drv_typed     = 1'b0;
        drv_res       = '0;

        // typed, mode, ax, ay, ar, as, ast, bx, by, br, bs, bst
        rows[0]  = '{1, '{0, 24'sd0, 24'sd0, 16'd256, 0, 0, 24'sd1000, 24'sd0, 16'd256, 0, 0}, '0};
        rows[1]  = '{1, '{0, 24'sd5, 24'sd5, 16'd900, 0, 0, 24'sd5, 24'sd5, 16'd900, 0, 0}, '0};
        rows[2]  = '{1, '{1, 24'sd0, 24'sd0, 16'd900, 0, 0, 24'sd2, 24'sd1, 16'd900, 0, 0}, '0};
        rows[3]  = '{1, '{0, 24'sd0, 24'sd0, 16'd0, 0, 0, 24'sd1, 24'sd1, 16'd0, 0, 0}, '0};
        rows[4]  = '{1, '{0, -24'sd8388608, -24'sd8388608, 16'hffff, 1, 1,
                          24'sd8388607, 24'sd8388607, 16'hffff, 1, 1}, '0};
        rows[5]  = '{1, '{0, 24'sd0, 24'sd0, 16'd100, 0, 0, 24'sd200, 24'sd0, 16'd100, 0, 0}, '0};
        rows[6]  = '{0, '{0, 24'sd0, 24'sd0, 16'd512, 0, 0, 24'sd300, 24'sd100, 16'd256, 0, 0}, '0};
        rows[7]  = '{0, '{0, 24'sd0, 24'sd0, 16'd512, 0, 0, -24'sd300, -24'sd100, 16'd256, 0, 0}, '0};
        rows[8]  = '{0, '{1, 24'sd0, 24'sd0, 16'd512, 1, 1, 24'sd300, -24'sd100, 16'd256, 0, 0}, '0};
        rows[9]  = '{0, '{1, 24'sd0, 24'sd0, 16'd512, 0, 0, 24'sd300, 24'sd100, 16'd256, 1, 0}, '0};
        rows[10] = '{0, '{1, 24'sd0, 24'sd0, 16'd512, 0, 0, 24'sd300, 24'sd100, 16'd256, 0, 1}, '0};
        rows[11] = '{0, '{0, 24'sd0, 24'sd0, 16'd512, 1, 0, 24'sd300, 24'sd100, 16'd256, 0, 0}, '0};
        rows[12] = '{0, '{0, 24'sd0, 24'sd0, 16'd512, 0, 0, 24'sd300, 24'sd100, 16'd256, 1, 0}, '0};
        rows[13] = '{0, '{0, 24'sd0, 24'sd0, 16'd512, 0, 1, 24'sd300, 24'sd100, 16'd256, 0, 0}, '0};
        rows[14] = '{0, '{0, 24'sd0, 24'sd0, 16'd512, 0, 0, 24'sd300, 24'sd100, 16'd256, 0, 1}, '0};
        rows[15] = '{0, '{0, 24'sd8388607, 24'sd8388607, 16'hffff, 0, 0,
                          24'sd8388604, 24'sd8388607, 16'hffff, 0, 0}, '0};
        rows[16] = '{0, '{0, -24'sd8388608, -24'sd8388608, 16'hffff, 0, 0,
                          -24'sd8388605, -24'sd8388608, 16'hffff, 0, 0}, '0};
        rows[17] = '{0, '{1, 24'sd0, 24'sd3, 16'hffff, 0, 0, 24'sd0, 24'sd0, 16'hffff, 0, 0}, '0};

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_ROWS; i++)
            send_pair(rows[i].pair, rows[i].typed, rows[i].res, 1);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
                while (pending_pushes.size() != 0)
                    @(posedge clk);
            end
            p = random_pair();
            send_pair(p, 1'b0, zero_res, (i / 150) % 3 != 1);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;

        while (pending_pushes.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);

        $display("sent %0d circle pairs, checked %0d items, %0d with overlap",
                 pairs_sent, results_seen, hits_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end
endmodule
